[rtl/mrr_pkg.sv]
// ---------------------------------------------------------------------------
// mrr_pkg: shared types and helpers of the Modbus RTU response receiver
// Word types, function codes, frame types and the byte-wide CRC-16 update.
// ---------------------------------------------------------------------------
package mrr_pkg;

    // frame limit: a position at this value wraps to the start of a new frame
    localparam logic [7:0]  MAX_FRAME_BYTES     = 8'd255;

    // function codes
    localparam logic [7:0]  FN_READ_HOLDING     = 8'h03;
    localparam logic [7:0]  FN_READ_INPUT       = 8'h04;
    localparam logic [7:0]  FN_PRESET_SINGLE    = 8'h06;
    localparam logic [7:0]  FN_PRESET_MULTIPLE  = 8'h10;
    localparam logic [7:0]  FN_EXCEPTION_BASE   = 8'h80;

    // crc-16/modbus
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY            = 16'hA001;

    // frame lengths in bytes
    localparam logic [8:0]  READ_OVERHEAD       = 9'd5;
    localparam logic [8:0]  PRESET_LENGTH       = 9'd8;
    localparam logic [8:0]  EXCEPTION_LENGTH    = 9'd5;

    // byte positions with a fixed meaning
    localparam logic [7:0]  POS_ADDRESS         = 8'd0;
    localparam logic [7:0]  POS_FUNCTION        = 8'd1;
    localparam logic [7:0]  POS_COUNT           = 8'd2;
    localparam logic [7:0]  POS_PAYLOAD         = 8'd3;
    localparam logic [7:0]  POS_FIRST_WORD      = 8'd4;

    // input commands
    localparam logic        CMD_RECEIVE         = 1'b0;
    localparam logic        CMD_CLEAR           = 1'b1;

    // result kinds
    localparam logic        KIND_WORD           = 1'b0;
    localparam logic        KIND_END            = 1'b1;

    typedef enum logic [2:0] {
        TYPE_READ_INPUT      = 3'd0,
        TYPE_READ_HOLDING    = 3'd1,
        TYPE_PRESET_SINGLE   = 3'd2,
        TYPE_PRESET_MULTIPLE = 3'd3,
        TYPE_EXCEPTION       = 3'd4
    } frame_type_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } mrr_in_t;

    typedef struct packed {
        logic        kind;
        frame_type_t frame_type;
        logic [7:0]  server_address;
        logic [6:0]  word_index;
        logic [15:0] word_value;
        logic [6:0]  word_count;
        logic [15:0] reg_address;
        logic [15:0] reg_data;
        logic [6:0]  original_function;
        logic [7:0]  exception_code;
        logic        crc_ok;
    } mrr_out_t;

    // framing status seen by the top level
    typedef struct packed {
        logic [7:0] byte_pos;
        logic [8:0] exp_len;
    } mrr_status_t;

    // one byte through the reflected crc-16, eight shift steps
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic is_read(input logic [7:0] fn);
        return (fn == FN_READ_HOLDING) || (fn == FN_READ_INPUT);
    endfunction

    function automatic logic code_accepted(input logic [7:0] fn);
        return is_read(fn) || (fn == FN_PRESET_SINGLE) || (fn == FN_PRESET_MULTIPLE)
            || (fn >= FN_EXCEPTION_BASE);
    endfunction

    function automatic frame_type_t type_of(input logic [7:0] fn);
        frame_type_t t;
        if (fn == FN_READ_INPUT)
            t = TYPE_READ_INPUT;
        else if (fn == FN_READ_HOLDING)
            t = TYPE_READ_HOLDING;
        else if (fn == FN_PRESET_SINGLE)
            t = TYPE_PRESET_SINGLE;
        else if (fn == FN_PRESET_MULTIPLE)
            t = TYPE_PRESET_MULTIPLE;
        else
            t = TYPE_EXCEPTION;
        return t;
    endfunction

endpackage

[rtl/modbus_rtu_response_receiver_top.sv]
// A result word is registered in the result register once its input word moves on
// from the input register, and is held there until it is taken.
// Throughput: one input word per cycle; the CRC byte update and position logic
// sit in the single stage between the input register and the result register.
// Stalls only when the result register is full and not being taken.
// Reset: asynchronous, active low; position and lengths clear, CRC to 0xFFFF.
// ---------------------------------------------------------------------------
// modbus_rtu_response_receiver_top: Modbus RTU master response receiver
// Frames received bytes into register words and frame ends with CRC check.
// ---------------------------------------------------------------------------
module modbus_rtu_response_receiver_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  mrr_pkg::mrr_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output mrr_pkg::mrr_out_t result
);
    import mrr_pkg::*;

    logic        held_valid;
    mrr_in_t     held_item;
    logic        out_free;
    logic        advance;
    logic        core_has_result;
    mrr_out_t    core_result;
    mrr_status_t status;

    // held word moves on when the result register has room
    assign advance = held_valid && out_free;

    mrr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    mrr_frame_core u_frame_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .item       (held_item),
        .has_result (core_has_result),
        .result     (core_result),
        .status     (status)
    );

    mrr_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .has_result   (core_has_result),
        .next_result  (core_result),
        .free         (out_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // a clear command always returns the frame to its first byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (held_item.cmd == CMD_CLEAR)) |=> (status.byte_pos == POS_ADDRESS))
        else $error("clear did not reset the byte position");

    // register words only come from read responses
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.kind == KIND_WORD)) |->
        ((result.frame_type == TYPE_READ_INPUT) || (result.frame_type == TYPE_READ_HOLDING)))
        else $error("register word from a non-read frame");

    // a stalled input word is neither lost nor replaced
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid && !advance) |=> (held_valid && $stable(held_item)))
        else $error("held input word changed while stalled");

    // once past the header the frame length is at least the shortest frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.byte_pos > POS_COUNT) |-> (status.exp_len >= EXCEPTION_LENGTH))
        else $error("payload position with no valid frame length");

endmodule

[rtl/mrr_in_stage.sv]
// ---------------------------------------------------------------------------
// mrr_in_stage: input register
// Captures one input word; refills in the same cycle the held word moves on.
// ---------------------------------------------------------------------------
module mrr_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  mrr_pkg::mrr_in_t item,
    input  logic            take,
    output logic            held_valid,
    output mrr_pkg::mrr_in_t held_item
);
    import mrr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    mrr_in_t data_reg;

    // free when empty or when the held word leaves this cycle
    assign item_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
            valid_next = item_valid;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            data_reg <= item;
    end

    assign held_valid = valid_reg;
    assign held_item  = data_reg;

endmodule

[rtl/mrr_frame_core.sv]
// ---------------------------------------------------------------------------
// mrr_frame_core: frame tracking and result decode
// Holds the framing state and builds at most one result per input word.
// ---------------------------------------------------------------------------
module mrr_frame_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  mrr_pkg::mrr_in_t    item,
    output logic                has_result,
    output mrr_pkg::mrr_out_t   result,
    output mrr_pkg::mrr_status_t status
);
    import mrr_pkg::*;

    logic [7:0]  pos_reg,    pos_next;
    logic [8:0]  len_reg,    len_next;
    logic [7:0]  slave_reg,  slave_next;
    logic [7:0]  fn_reg,     fn_next;
    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  held_reg,   held_next;
    logic [31:0] shift_reg,  shift_next;
    logic [15:0] crcb_reg,   crcb_next;

    logic [7:0]  b;
    logic [7:0]  p;
    logic [8:0]  p9;
    logic [8:0]  pq;
    logic [8:0]  bc;
    logic [7:0]  wi;
    logic        rd;
    frame_type_t t;

    assign b  = item.rx_byte;
    assign rd = is_read(fn_reg);
    assign t  = type_of(fn_reg);
    assign bc = len_reg - READ_OVERHEAD;
    // wrap a frame that has reached the size limit
    assign p  = (pos_reg >= MAX_FRAME_BYTES) ? POS_ADDRESS : pos_reg;
    assign p9 = {1'b0, p};
    assign wi = p - POS_FIRST_WORD;

    // next state and result
    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        slave_next = slave_reg;
        fn_next    = fn_reg;
        crc_next   = crc_reg;
        held_next  = held_reg;
        shift_next = shift_reg;
        crcb_next  = crcb_reg;
        pq         = p9;
        has_result = 1'b0;
        result     = '0;
        if (step)
        begin
            if (item.cmd == CMD_CLEAR)
            begin
                pos_next = POS_ADDRESS;
            end
            else if (p == POS_ADDRESS)
            begin
                slave_next = b;
                crc_next   = crc16_update(CRC_INIT, b);
                shift_next = '0;
                crcb_next  = '0;
                held_next  = '0;
                pos_next   = POS_FUNCTION;
            end
            else if (p == POS_FUNCTION)
            begin
                fn_next = b;
                if (code_accepted(b))
                begin
                    crc_next = crc16_update(crc_reg, b);
                    pos_next = POS_COUNT;
                end
                else
                begin
                    pos_next = POS_ADDRESS;
                end
            end
            else if (p == POS_COUNT)
            begin
                crc_next = crc16_update(crc_reg, b);
                if (rd)
                    len_next = {1'b0, b} + READ_OVERHEAD;
                else if (fn_reg >= FN_EXCEPTION_BASE)
                    len_next = EXCEPTION_LENGTH;
                else
                    len_next = PRESET_LENGTH;
                pos_next = POS_PAYLOAD;
            end
            else
            begin
                // payload byte or one of the two trailing crc bytes
                if ((p9 + 9'd2) < len_reg)
                begin
                    crc_next   = crc16_update(crc_reg, b);
                    shift_next = {shift_reg[23:0], b};
                    held_next  = b;
                    if (rd && (p >= POS_FIRST_WORD) && !p[0])
                    begin
                        has_result            = 1'b1;
                        result.kind           = KIND_WORD;
                        result.frame_type     = t;
                        result.server_address = slave_reg;
                        result.word_index     = wi[7:1];
                        result.word_value     = {held_reg, b};
                        result.word_count     = bc[7:1];
                    end
                end
                else
                begin
                    crcb_next = {crcb_reg[7:0], b};
                end

                if (len_reg > p9)
                    pq = p9 + 9'd1;

                // frame end
                if (len_reg == pq)
                begin
                    has_result            = 1'b1;
                    result.kind           = KIND_END;
                    result.frame_type     = t;
                    result.server_address = slave_reg;
                    result.word_count     = rd ? bc[7:1] : 7'd0;
                    if ((t == TYPE_PRESET_SINGLE) || (t == TYPE_PRESET_MULTIPLE))
                    begin
                        result.reg_address = shift_next[31:16];
                        result.reg_data    = shift_next[15:0];
                    end
                    if (t == TYPE_EXCEPTION)
                    begin
                        result.original_function = fn_reg[6:0];
                        result.exception_code    = shift_next[7:0];
                    end
                    result.crc_ok = (crc_next == crcb_next);
                    pos_next      = POS_ADDRESS;
                end
                else
                begin
                    pos_next = pq[7:0];
                end
            end
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            len_reg   <= '0;
            slave_reg <= '0;
            fn_reg    <= '0;
            crc_reg   <= CRC_INIT;
            held_reg  <= '0;
            shift_reg <= '0;
            crcb_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            slave_reg <= slave_next;
            fn_reg    <= fn_next;
            crc_reg   <= crc_next;
            held_reg  <= held_next;
            shift_reg <= shift_next;
            crcb_reg  <= crcb_next;
        end
    end

    assign status.byte_pos = pos_reg;
    assign status.exp_len  = len_reg;

endmodule

[rtl/mrr_out_stage.sv]
// ---------------------------------------------------------------------------
// mrr_out_stage: result register
// Holds one result word until the consumer takes it.
// ---------------------------------------------------------------------------
module mrr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              has_result,
    input  mrr_pkg::mrr_out_t next_result,
    output logic              free,
    output logic              result_valid,
    input  logic              result_ready,
    output mrr_pkg::mrr_out_t result
);
    import mrr_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    mrr_out_t data_reg;

    // room when empty or when the held word is taken this cycle
    assign free = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = has_result;
        else if (result_ready)
            valid_next = 1'b0;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load && has_result)
            data_reg <= next_result;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

[tb/sv/modbus_rtu_response_receiver_top_tb.sv]
// ---------------------------------------------------------------------------
// modbus_rtu_response_receiver_top_tb: self-checking bench of the response receiver
// Drives framed Modbus RTU responses, cut and dropped frames, clears and noise
// into the input channel, and predicts every register word and frame end.
// A scoreboard object keeps its own copy of the framing state and checks each
// result field by field; both channels idle and stall at random.
// ---------------------------------------------------------------------------
module modbus_rtu_response_receiver_top_tb;

    import mrr_pkg::*;

    // framing tracker: own copy of the receiver state and the words it is due
    class frame_tracker;
        bit [7:0]  position;
        bit [8:0]  frame_length;
        bit [7:0]  slave;
        bit [7:0]  func;
        bit [15:0] crc_calc;
        bit [7:0]  held;
        bit [31:0] shift;
        bit [15:0] crc_rx;
        mrr_out_t  due_results[$];
        int        errors;

        function new();
            position     = POS_ADDRESS;
            frame_length = '0;
            slave        = '0;
            func         = '0;
            crc_calc     = CRC_INIT;
            held         = '0;
            shift        = '0;
            crc_rx       = '0;
            errors       = 0;
        endfunction

        function bit [15:0] crc_next(bit [15:0] c, bit [7:0] b);
            bit [15:0] r;
            r = c ^ {8'h00, b};
            for (int i = 0; i < 8; i++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function bit reads(bit [7:0] fn);
            return (fn == FN_READ_HOLDING) || (fn == FN_READ_INPUT);
        endfunction

        function bit accepts(bit [7:0] fn);
            return reads(fn) || (fn == FN_PRESET_SINGLE) || (fn == FN_PRESET_MULTIPLE)
                || (fn >= FN_EXCEPTION_BASE);
        endfunction

        function frame_type_t kind_of(bit [7:0] fn);
            if (fn == FN_READ_INPUT)
                return TYPE_READ_INPUT;
            if (fn == FN_READ_HOLDING)
                return TYPE_READ_HOLDING;
            if (fn == FN_PRESET_SINGLE)
                return TYPE_PRESET_SINGLE;
            if (fn == FN_PRESET_MULTIPLE)
                return TYPE_PRESET_MULTIPLE;
            return TYPE_EXCEPTION;
        endfunction

        // byte count halved, only for reads
        function bit [6:0] words_in_frame();
            bit [8:0] d;
            if (!reads(func) || frame_length < READ_OVERHEAD)
                return '0;
            d = frame_length - READ_OVERHEAD;
            return d[7:1];
        endfunction

        // advance the framing state by one accepted word
        function void take_item(mrr_in_t w);
            bit [7:0]    b;
            int          p;
            int          e;
            mrr_out_t    o;
            frame_type_t t;
            if (w.cmd == CMD_CLEAR)
            begin
                position = POS_ADDRESS;
                return;
            end
            b = w.rx_byte;
            p = position;
            // size limit reached: this byte opens a new frame
            if (p >= MAX_FRAME_BYTES)
                p = POS_ADDRESS;
            if (p == POS_ADDRESS)
            begin
                slave    = b;
                crc_calc = crc_next(CRC_INIT, b);
                shift    = '0;
                crc_rx   = '0;
                held     = '0;
                position = POS_FUNCTION;
                return;
            end
            if (p == POS_FUNCTION)
            begin
                func = b;
                if (accepts(b))
                begin
                    crc_calc = crc_next(crc_calc, b);
                    position = POS_COUNT;
                end
                else
                    position = POS_ADDRESS;
                return;
            end
            if (p == POS_COUNT)
            begin
                crc_calc = crc_next(crc_calc, b);
                if (reads(func))
                    frame_length = {1'b0, b} + READ_OVERHEAD;
                else if (func >= FN_EXCEPTION_BASE)
                    frame_length = EXCEPTION_LENGTH;
                else
                    frame_length = PRESET_LENGTH;
                position = POS_PAYLOAD;
                return;
            end
            e = frame_length;
            // payload byte, or one of the two trailing crc bytes
            if (p + 2 < e)
            begin
                crc_calc = crc_next(crc_calc, b);
                shift    = {shift[23:0], b};
                if (reads(func) && p >= POS_FIRST_WORD && (p % 2) == 0)
                begin
                    o                = '0;
                    o.kind           = KIND_WORD;
                    o.frame_type     = kind_of(func);
                    o.server_address = slave;
                    o.word_index     = 7'((p - POS_FIRST_WORD) >> 1);
                    o.word_value     = {held, b};
                    o.word_count     = words_in_frame();
                    due_results.push_back(o);
                end
                held = b;
            end
            else
                crc_rx = {crc_rx[7:0], b};
            if (e > p)
                p++;
            // frame end
            if (e == p)
            begin
                t                = kind_of(func);
                o                = '0;
                o.kind           = KIND_END;
                o.frame_type     = t;
                o.server_address = slave;
                o.word_count     = words_in_frame();
                if (t == TYPE_PRESET_SINGLE || t == TYPE_PRESET_MULTIPLE)
                begin
                    o.reg_address = shift[31:16];
                    o.reg_data    = shift[15:0];
                end
                if (t == TYPE_EXCEPTION)
                begin
                    o.original_function = 7'(func - FN_EXCEPTION_BASE);
                    o.exception_code    = shift[7:0];
                end
                o.crc_ok = (crc_calc == crc_rx);
                due_results.push_back(o);
                p = POS_ADDRESS;
            end
            position = 8'(p);
        endfunction

        function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s expected 0x%0h actual 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one accepted result with the oldest due one
        function void match_result(mrr_out_t r);
            mrr_out_t x;
            if (due_results.size() == 0)
            begin
                $error("result word with none due: 0x%0h", r);
                errors++;
                return;
            end
            x = due_results.pop_front();
            check_field("kind", x.kind, r.kind);
            check_field("frame_type", x.frame_type, r.frame_type);
            check_field("server_address", x.server_address, r.server_address);
            check_field("word_index", x.word_index, r.word_index);
            check_field("word_value", x.word_value, r.word_value);
            check_field("word_count", x.word_count, r.word_count);
            check_field("reg_address", x.reg_address, r.reg_address);
            check_field("reg_data", x.reg_data, r.reg_data);
            check_field("original_function", x.original_function, r.original_function);
            check_field("exception_code", x.exception_code, r.exception_code);
            check_field("crc_ok", x.crc_ok, r.crc_ok);
        endfunction
    endclass

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     item_valid;
    logic     item_ready;
    mrr_in_t  item;
    logic     result_valid;
    logic     result_ready;
    mrr_out_t result;

    frame_tracker board;
    bit [7:0]     frame_q[$];
    bit           frame_wraps;
    int           items_sent;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_req;
    int           hold_seen;
    int           hold_left;
    int           quiet_cycles;

    modbus_rtu_response_receiver_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check accepted words, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.match_result(result);
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one word, with a random gap ahead of it, and wait for acceptance
    task automatic send_word(input logic c, input logic [7:0] b);
        mrr_in_t w;
        w.cmd     = c;
        w.rx_byte = b;
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        item       <= w;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        board.take_item(w);
        items_sent++;
    endtask

    function automatic void start_frame(bit [7:0] addr, bit [7:0] fn);
        frame_q = {};
        frame_q.push_back(addr);
        frame_q.push_back(fn);
        frame_wraps = 1'b0;
    endfunction

    // append the crc, high byte first, optionally corrupted
    function automatic void close_frame(bit good);
        bit [15:0] c;
        c = CRC_INIT;
        foreach (frame_q[i])
            c = board.crc_next(c, frame_q[i]);
        if (!good)
            c ^= 16'(1 << $urandom_range(15));
        frame_q.push_back(c[15:8]);
        frame_q.push_back(c[7:0]);
    endfunction

    // send the built frame; a clear replaces the byte at cut
    task automatic send_frame(input int cut);
        for (int i = 0; i < frame_q.size(); i++)
        begin
            if (i == cut)
            begin
                send_word(CMD_CLEAR, 8'($urandom_range(255)));
                return;
            end
            send_word(CMD_RECEIVE, frame_q[i]);
        end
    endtask

    function automatic void build_read(bit [7:0] fn, int cnt, bit good);
        start_frame(8'($urandom_range(255)), fn);
        frame_q.push_back(8'(cnt));
        for (int i = 0; i < cnt; i++)
            frame_q.push_back(8'($urandom_range(255)));
        close_frame(good);
        frame_wraps = (cnt + READ_OVERHEAD > MAX_FRAME_BYTES);
    endfunction

    // well-formed frame of a random type with random content
    function automatic void build_random_frame(bit good);
        int sel;
        int cnt;
        sel = $urandom_range(4);
        if (sel < 2)
        begin
            cnt = ($urandom_range(39) == 0) ? $urandom_range(240, 255) : $urandom_range(16);
            build_read((sel == 0) ? FN_READ_INPUT : FN_READ_HOLDING, cnt, good);
        end
        else if (sel < 4)
        begin
            start_frame(8'($urandom_range(255)),
                        (sel == 2) ? FN_PRESET_SINGLE : FN_PRESET_MULTIPLE);
            repeat (4) frame_q.push_back(8'($urandom_range(255)));
            close_frame(good);
        end
        else
        begin
            start_frame(8'($urandom_range(255)), 8'($urandom_range(128, 255)));
            frame_q.push_back(8'($urandom_range(255)));
            close_frame(good);
        end
    endfunction

    // random traffic until the running word total reaches target
    task automatic random_traffic(input int target, input int hold_at);
        int       r;
        bit [7:0] fn;
        while (items_sent < target)
        begin
            if (hold_at > 0 && items_sent >= hold_at)
            begin
                hold_req++;
                hold_at = 0;
            end
            r = $urandom_range(99);
            if (r < 72)
            begin
                build_random_frame($urandom_range(9) != 0);
                send_frame(-1);
                if (frame_wraps)
                    send_word(CMD_CLEAR, 8'($urandom_range(255)));
            end
            else if (r < 82)
            begin
                build_random_frame($urandom_range(9) != 0);
                send_frame($urandom_range(frame_q.size() - 1));
            end
            else if (r < 90)
            begin
                // code outside the accepted set drops the frame
                do
                    fn = 8'($urandom_range(127));
                while (board.accepts(fn));
                start_frame(8'($urandom_range(255)), fn);
                send_frame(-1);
            end
            else
            begin
                // line noise, then a clear to get back in step
                repeat ($urandom_range(1, 6))
                    send_word(CMD_RECEIVE, 8'($urandom_range(255)));
                send_word(CMD_CLEAR, 8'($urandom_range(255)));
            end
        end
    endtask

    // sender pause until every due result has arrived
    task automatic drain();
        item_valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        board         = new();
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        result_ready  = 1'b0;
        items_sent    = 0;
        hold_req      = 0;
        hold_seen     = 0;
        hold_left     = 0;
        quiet_cycles  = 0;
        send_idle_pct = 19;
        recv_idle_pct = 73;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // exception frame with all-ones fields
        start_frame(8'hFF, 8'hFF);
        frame_q.push_back(8'hFF);
        close_frame(1'b1);
        send_frame(-1);
        // read with odd byte count and a corrupted crc
        start_frame(8'h00, FN_READ_INPUT);
        frame_q.push_back(8'd3);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'hA5);
        close_frame(1'b0);
        send_frame(-1);
        // unsupported function code
        start_frame(8'h11, 8'h7F);
        send_frame(-1);
        // clear part way through a read
        start_frame(8'h22, FN_READ_HOLDING);
        frame_q.push_back(8'd4);
        frame_q.push_back(8'h12);
        send_frame(3);
        // preset single echo
        start_frame(8'h01, FN_PRESET_SINGLE);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        frame_q.push_back(8'h80);
        frame_q.push_back(8'h7F);
        close_frame(1'b1);
        send_frame(-1);
        // longest frame that still ends
        build_read(FN_READ_HOLDING, 250, 1'b1);
        send_frame(-1);

        // slow receiver, with one long hold while the sender keeps going
        random_traffic(500, 320);
        drain();

        // slow sender
        send_idle_pct = 73;
        recv_idle_pct = 19;
        random_traffic(980, 0);
        drain();

        // no idling; read that runs past the size limit first
        send_idle_pct = 0;
        recv_idle_pct = 0;
        build_read(FN_READ_INPUT, 255, 1'b1);
        send_frame(-1);
        send_word(CMD_CLEAR, 8'($urandom_range(255)));
        random_traffic(1450, 0);
        drain();

        if (board.due_results.size() != 0)
        begin
            $error("%0d result words never arrived", board.due_results.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/mrr_pkg.sv
rtl/mrr_in_stage.sv
rtl/mrr_frame_core.sv
rtl/mrr_out_stage.sv
rtl/modbus_rtu_response_receiver_top.sv
tb/sv/modbus_rtu_response_receiver_top_tb.sv
